>>> src/mcid_pkg.sv
// ----------------------------------------------------------------------------
// mcid_pkg
// Shared types and constants of the multi-channel input debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcid_pkg;

  localparam int unsigned NCH_MAX    = 3;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef logic [1:0]       level_t;
  typedef logic [CFG_W-1:0] cfg_byte_t;

  localparam level_t LVL_LOW     = 2'd0;
  localparam level_t LVL_HIGH    = 2'd1;
  localparam level_t LVL_UNKNOWN = 2'd2;

  // register indexes
  localparam logic [2:0] REG_STARTUP   = 3'd0;
  localparam logic [2:0] REG_PERIOD_0  = 3'd1;
  localparam logic [2:0] REG_PERIOD_1  = 3'd2;
  localparam logic [2:0] REG_PERIOD_2  = 3'd3;
  localparam logic [2:0] REG_CONFIRM_0 = 3'd4;
  localparam logic [2:0] REG_CONFIRM_1 = 3'd5;
  localparam logic [2:0] REG_CONFIRM_2 = 3'd6;

  localparam cfg_byte_t RST_STARTUP   = 8'd20;
  localparam cfg_byte_t RST_PERIOD_0  = 8'd20;
  localparam cfg_byte_t RST_PERIOD_1  = 8'd20;
  localparam cfg_byte_t RST_PERIOD_2  = 8'd5;
  localparam cfg_byte_t RST_CONFIRM_0 = 8'd3;
  localparam cfg_byte_t RST_CONFIRM_1 = 8'd3;
  localparam cfg_byte_t RST_CONFIRM_2 = 8'd2;

  typedef struct packed {
    logic                          startup_wr;
    cfg_byte_t                     startup_ticks;
    logic [NCH_MAX-1:0][CFG_W-1:0] sample_period;
    logic [NCH_MAX-1:0][CFG_W-1:0] confirm_count;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/mcid_regs.sv
// ----------------------------------------------------------------------------
// mcid_regs
// APB register file holding start-up and per-channel debounce settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcid_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcid_pkg::APB_AW-1:0]   paddr,
  input  wire logic [mcid_pkg::APB_DW-1:0]   pwdata,
  output logic      [mcid_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output mcid_pkg::cfg_t                     cfg_o
);
  import mcid_pkg::*;

  logic       wr_en;
  logic [2:0] idx;
  cfg_byte_t  wval;
  cfg_byte_t  startup_q;
  logic [NCH_MAX-1:0][CFG_W-1:0] period_q;
  logic [NCH_MAX-1:0][CFG_W-1:0] confirm_q;
  cfg_byte_t  rval;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];
  assign wval   = pwdata[CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_q    <= RST_STARTUP;
      period_q[0]  <= RST_PERIOD_0;
      period_q[1]  <= RST_PERIOD_1;
      period_q[2]  <= RST_PERIOD_2;
      confirm_q[0] <= RST_CONFIRM_0;
      confirm_q[1] <= RST_CONFIRM_1;
      confirm_q[2] <= RST_CONFIRM_2;
    end else if (wr_en) begin
      unique case (idx)
        REG_STARTUP:   startup_q    <= wval;
        REG_PERIOD_0:  period_q[0]  <= wval;
        REG_PERIOD_1:  period_q[1]  <= wval;
        REG_PERIOD_2:  period_q[2]  <= wval;
        REG_CONFIRM_0: confirm_q[0] <= wval;
        REG_CONFIRM_1: confirm_q[1] <= wval;
        REG_CONFIRM_2: confirm_q[2] <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STARTUP:   rval = startup_q;
      REG_PERIOD_0:  rval = period_q[0];
      REG_PERIOD_1:  rval = period_q[1];
      REG_PERIOD_2:  rval = period_q[2];
      REG_CONFIRM_0: rval = confirm_q[0];
      REG_CONFIRM_1: rval = confirm_q[1];
      REG_CONFIRM_2: rval = confirm_q[2];
      default:       rval = '0;
    endcase
  end

  assign prdata = {{(APB_DW-CFG_W){1'b0}}, rval};

  assign cfg_o.startup_wr    = wr_en && (idx == REG_STARTUP);
  assign cfg_o.startup_ticks = wval;
  assign cfg_o.sample_period = period_q;
  assign cfg_o.confirm_count = confirm_q;

endmodule

`default_nettype wire

>>> src/mcid_channel.sv
// ----------------------------------------------------------------------------
// mcid_channel
// One debounce channel: sample timer, match counter and stable level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcid_channel (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 level_i,
  input  wire mcid_pkg::cfg_byte_t  period_i,
  input  wire mcid_pkg::cfg_byte_t  confirm_i,
  output mcid_pkg::level_t          stable_d_o
);
  import mcid_pkg::*;

  cfg_byte_t timer_q, timer_d;
  cfg_byte_t match_q, match_d;
  level_t    last_q, last_d;
  level_t    stable_q, stable_d;
  level_t    lvl;
  logic      take;

  assign lvl  = {1'b0, level_i};
  assign take = step_i && (timer_q == '0);

  always_comb begin
    timer_d  = timer_q;
    match_d  = match_q;
    last_d   = last_q;
    stable_d = stable_q;
    if (step_i) begin
      if (take) begin
        timer_d = period_i;
        if (lvl == last_q) begin
          if (match_q < confirm_i) match_d = match_q + 8'd1;
        end else begin
          match_d = 8'd1;
        end
        last_d = lvl;
        if (match_d >= confirm_i) stable_d = lvl;
      end else begin
        timer_d = timer_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q  <= '0;
      match_q  <= 8'd1;
      last_q   <= LVL_UNKNOWN;
      stable_q <= LVL_UNKNOWN;
    end else begin
      timer_q  <= timer_d;
      match_q  <= match_d;
      last_q   <= last_d;
      stable_q <= stable_d;
    end
  end

  assign stable_d_o = stable_d;

endmodule

`default_nettype wire

>>> src/multi_channel_input_debouncer.sv
// ----------------------------------------------------------------------------
// multi_channel_input_debouncer
// Start-up wait, per-channel sampled debounce and registered result beat.
// ----------------------------------------------------------------------------
// Usage: each input beat on the s_axis channel is one tick carrying the raw
// levels of up to three pins. Every accepted beat yields exactly one result
// beat on m_axis with the debounced state of each channel (low, high or
// unknown) and a polling-active flag.
// The result of a tick is in the output register the cycle after it is
// accepted. Throughput is one beat per cycle while m_axis_tready is high;
// the limit is the single output register, which is refilled in the cycle it
// is taken. When the receiver stalls, the output beat holds and
// s_axis_tready drops until it is taken.
// Reset loads the register defaults, reloads the start-up counter, sets all
// channels to unknown and empties the output register. Ticks during the
// start-up wait produce beats too, with polling inactive. The user must
// write the APB port only while no beat is in flight, which is not enforced.
// A start-up register write also reloads the counter while polling is off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_input_debouncer #(
  parameter int unsigned CHANNELS = mcid_pkg::NCH_MAX
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // apb
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mcid_pkg::APB_AW-1:0]      paddr,
  input  wire logic [mcid_pkg::APB_DW-1:0]      pwdata,
  output logic      [mcid_pkg::APB_DW-1:0]      prdata,
  output logic                                  pready,
  // input ticks
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // level_0, level_1, level_2, zero pad
  input  wire logic [mcid_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // results
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // stable_0[1:0], stable_1[3:2], stable_2[5:4], polling_active, zero pad
  output logic      [mcid_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mcid_pkg::*;

  cfg_t      cfg;
  logic      accept;
  logic      step;
  cfg_byte_t startup_q, startup_d;
  logic      polling_q, polling_d;
  level_t [NCH_MAX-1:0] stable_d;
  logic      out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  mcid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step          = accept && polling_q;

  always_comb begin
    startup_d = startup_q;
    polling_d = polling_q;
    if (accept && !polling_q) begin
      if (startup_q != '0) startup_d = startup_q - 8'd1;
      if (startup_d == '0) polling_d = 1'b1;
    end else if (cfg.startup_wr && !polling_q) begin
      startup_d = cfg.startup_ticks;
    end
  end

  for (genvar g = 0; g < NCH_MAX; g++) begin : g_ch
    if (g < CHANNELS) begin : g_used
      mcid_channel u_ch (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .step_i     (step),
        .level_i    (s_axis_tdata[g]),
        .period_i   (cfg.sample_period[g]),
        .confirm_i  (cfg.confirm_count[g]),
        .stable_d_o (stable_d[g])
      );
    end else begin : g_unused
      assign stable_d[g] = LVL_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_q   <= RST_STARTUP;
      polling_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      startup_q <= startup_d;
      polling_q <= polling_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {1'b0, polling_d, stable_d[2], stable_d[1], stable_d[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // polling never switches off without reset
  a_polling_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    polling_q |=> polling_q)
    else $error("polling switched off");

  // an accepted tick always leaves a result beat
  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // before polling, every channel reads unknown
  a_unknown_startup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[6]) |->
      (m_axis_tdata[1:0] == LVL_UNKNOWN && m_axis_tdata[3:2] == LVL_UNKNOWN &&
       m_axis_tdata[5:4] == LVL_UNKNOWN))
    else $error("channel state known before polling");

  // the start-up counter is zero once polling runs
  a_startup_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    polling_q |-> (startup_q == '0))
    else $error("polling with start-up counter running");

endmodule

`default_nettype wire

>>> verif/tb_multi_channel_input_debouncer.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_input_debouncer
// Self-checking bench for the three-channel sampled debouncer. Tick beats are
// driven from a queue, each accepted tick is run through a local cycle model
// of the start-up wait and the per-channel sample timers and confirm
// counters, and every result beat is compared field by field with the oldest
// prediction. Register settings change between phases over APB, with random
// idling on both sides, a long receiver stall and a drained sender pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_channel_input_debouncer;
  import mcid_pkg::*;

  localparam int         NCH          = 3;
  localparam int         LIMIT_CYCLES = 500000;
  localparam int         LONG_HOLD    = 300;
  localparam logic [2:0] REG_UNUSED   = 3'd7;

  typedef struct packed {
    logic   poll;
    level_t st2;
    level_t st1;
    level_t st0;
  } debounce_out_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_AW-1:0]      paddr         = '0;
  logic [APB_DW-1:0]      pwdata        = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // level_0, level_1, level_2, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // stable_0[1:0], stable_1[3:2], stable_2[5:4], polling_active, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  multi_channel_input_debouncer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // register mirror and debouncer state
  cfg_byte_t     cfg_startup;
  cfg_byte_t     cfg_period  [NCH];
  cfg_byte_t     cfg_confirm [NCH];
  cfg_byte_t     startup_left;
  logic          pol_on;
  cfg_byte_t     smp_timer   [NCH];
  level_t        last_lv     [NCH];
  cfg_byte_t     match_cnt   [NCH];
  level_t        stable_lv   [NCH];

  logic [2:0]    tick_q [$];
  debounce_out_t state_q [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_req     = 0;
  int hold_ack     = 0;
  int hold_left    = 0;
  int cycle_cnt    = 0;
  int ticks_done   = 0;
  int results_seen = 0;
  int err_cnt      = 0;
  int settings_cnt = 0;

  logic       gen_level [NCH];
  int         gen_left  [NCH];

  function automatic debounce_out_t debounce_tick(input logic [2:0] lv);
    debounce_out_t o;
    level_t        smp;
    if (!pol_on) begin
      if (startup_left != 0) startup_left = startup_left - 8'd1;
      if (startup_left == 0) pol_on = 1'b1;
    end else begin
      for (int c = 0; c < NCH; c++) begin
        if (smp_timer[c] == 0) begin
          smp = lv[c] ? LVL_HIGH : LVL_LOW;
          if (smp == last_lv[c]) begin
            if (match_cnt[c] < cfg_confirm[c]) match_cnt[c] = match_cnt[c] + 8'd1;
          end else begin
            match_cnt[c] = 8'd1;
          end
          last_lv[c] = smp;
          if (match_cnt[c] >= cfg_confirm[c]) stable_lv[c] = smp;
          smp_timer[c] = cfg_period[c];
        end else begin
          smp_timer[c] = smp_timer[c] - 8'd1;
        end
      end
    end
    o.st0  = stable_lv[0];
    o.st1  = stable_lv[1];
    o.st2  = stable_lv[2];
    o.poll = pol_on;
    return o;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) flag_error($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        state_q.push_back(debounce_tick(s_axis_tdata[2:0]));
        ticks_done++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'd0, tick_q.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result ready, with long stalls on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_ack      <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack      <= hold_req;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin : monitor
    debounce_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = debounce_out_t'(m_axis_tdata[6:0]);
      if (state_q.size() == 0) begin
        flag_error($sformatf("result beat 0x%02h with nothing expected", m_axis_tdata));
      end else begin
        want = state_q.pop_front();
        results_seen++;
        check_field("stable_0", want.st0, got.st0);
        check_field("stable_1", want.st1, got.st1);
        check_field("stable_2", want.st2, got.st2);
        check_field("polling_active", want.poll, got.poll);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, state_q.size());
      $display("[multi_channel_input_debouncer] ERROR");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] idx, input cfg_byte_t v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STARTUP: begin
        cfg_startup = v;
        if (!pol_on) startup_left = v;
      end
      REG_PERIOD_0:  cfg_period[0]  = v;
      REG_PERIOD_1:  cfg_period[1]  = v;
      REG_PERIOD_2:  cfg_period[2]  = v;
      REG_CONFIRM_0: cfg_confirm[0] = v;
      REG_CONFIRM_1: cfg_confirm[1] = v;
      REG_CONFIRM_2: cfg_confirm[2] = v;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || state_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // level runs sized to confirm, up to a cap, mixed with bounces and noise
  task automatic push_ticks(input int n);
    logic [2:0] lv;
    int         r;
    int         need;
    int         cf;
    for (int k = 0; k < n; k++) begin
      for (int c = 0; c < NCH; c++) begin
        if (gen_left[c] == 0) begin
          r    = $urandom_range(99);
          cf   = (cfg_confirm[c] == 0) ? 1 : int'(cfg_confirm[c]);
          need = (int'(cfg_period[c]) + 1) * cf;
          if (need > 500) need = 500;
          if (r < 20) begin
            gen_level[c] = 1'($urandom_range(1));
            gen_left[c]  = 1;
          end else if (r < 35) begin
            gen_level[c] = ~gen_level[c];
            gen_left[c]  = $urandom_range(1, 3);
          end else begin
            gen_level[c] = ~gen_level[c];
            gen_left[c]  = $urandom_range(need, need + 2 * (int'(cfg_period[c]) + 1));
          end
        end
        lv[c] = gen_level[c];
        gen_left[c]--;
      end
      tick_q.push_back(lv);
    end
  endtask

  function automatic cfg_byte_t pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'd255;
    if (r < 30) return 8'd0;
    return cfg_byte_t'($urandom_range(1, 6));
  endfunction

  function automatic cfg_byte_t pick_confirm();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 8'd255;
    if (r < 20) return 8'd0;
    if (r < 35) return 8'd1;
    return cfg_byte_t'($urandom_range(2, 5));
  endfunction

  initial begin
    cfg_byte_t per [NCH];
    cfg_byte_t cnf [NCH];
    int        n;
    cfg_startup    = RST_STARTUP;
    cfg_period[0]  = RST_PERIOD_0;
    cfg_period[1]  = RST_PERIOD_1;
    cfg_period[2]  = RST_PERIOD_2;
    cfg_confirm[0] = RST_CONFIRM_0;
    cfg_confirm[1] = RST_CONFIRM_1;
    cfg_confirm[2] = RST_CONFIRM_2;
    startup_left   = RST_STARTUP;
    pol_on         = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      smp_timer[c] = '0;
      last_lv[c]   = LVL_UNKNOWN;
      match_cnt[c] = 8'd1;
      stable_lv[c] = LVL_UNKNOWN;
      gen_level[c] = 1'b0;
      gen_left[c]  = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // start-up wait, reload of the wait, zero wait switching polling on
    src_idle_pct = 33;
    snk_idle_pct = 68;
    tick_q.push_back(3'b000);
    tick_q.push_back(3'b111);
    wait_drained();
    apb_write(REG_STARTUP, 8'd255);
    tick_q.push_back(3'b101);
    wait_drained();
    apb_write(REG_STARTUP, 8'd0);
    tick_q.push_back(3'b010);
    wait_drained();

    // channels 0 and 1 sampling every tick with zero and single confirm
    apb_write(REG_PERIOD_0, 8'd0);
    apb_write(REG_PERIOD_1, 8'd0);
    apb_write(REG_PERIOD_2, 8'd1);
    apb_write(REG_CONFIRM_0, 8'd0);
    apb_write(REG_CONFIRM_1, 8'd1);
    apb_write(REG_CONFIRM_2, 8'd2);
    foreach (per[c]) per[c] = '0;
    tick_q.push_back(3'b000);
    tick_q.push_back(3'b111);
    tick_q.push_back(3'b111);
    tick_q.push_back(3'b010);
    tick_q.push_back(3'b101);
    tick_q.push_back(3'b111);
    tick_q.push_back(3'b000);
    tick_q.push_back(3'b000);
    tick_q.push_back(3'b110);
    tick_q.push_back(3'b001);
    wait_drained();

    // period change under a running timer, unused address, late start-up write
    apb_write(REG_PERIOD_2, 8'd255);
    apb_write(REG_UNUSED, 8'h5a);
    apb_write(REG_STARTUP, 8'd200);
    tick_q.push_back(3'b011);
    tick_q.push_back(3'b100);
    tick_q.push_back(3'b111);
    wait_drained();
    settings_cnt = 4;

    for (int ph = 0; ph < 12; ph++) begin
      src_idle_pct = (ph < 4) ? 33 : (ph < 8) ? 68 : 0;
      snk_idle_pct = (ph < 4) ? 68 : (ph < 8) ? 33 : 0;
      for (int c = 0; c < NCH; c++) begin
        case (ph)
          0: begin
            per[c] = 8'd255;
            cnf[c] = 8'd1;
          end
          6: begin
            per[c] = 8'd0;
            cnf[c] = 8'd255;
          end
          7: begin
            // confirm dropped below the count built up before
            per[c] = 8'd0;
            cnf[c] = 8'd2;
          end
          default: begin
            per[c] = pick_period();
            cnf[c] = pick_confirm();
          end
        endcase
      end
      apb_write(REG_STARTUP, cfg_byte_t'($urandom_range(255)));
      apb_write(REG_PERIOD_0, per[0]);
      apb_write(REG_PERIOD_1, per[1]);
      apb_write(REG_PERIOD_2, per[2]);
      apb_write(REG_CONFIRM_0, cnf[0]);
      apb_write(REG_CONFIRM_1, cnf[1]);
      apb_write(REG_CONFIRM_2, cnf[2]);
      settings_cnt++;
      n = (ph == 0) ? 300 : (ph == 6) ? 400 : 140;
      if (ph == 2) begin
        push_ticks(n);
        hold_req = hold_req + 1;
      end else if (ph == 5) begin
        push_ticks(n / 2);
        wait_drained();
        push_ticks(n / 2);
      end else begin
        push_ticks(n);
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    $display("%0d ticks through %0d register settings, %0d results compared, %0d mismatches",
             ticks_done, settings_cnt, results_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("[multi_channel_input_debouncer] OK");
    end else begin
      $display("[multi_channel_input_debouncer] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/mcid_pkg.sv
src/mcid_regs.sv
src/mcid_channel.sv
src/multi_channel_input_debouncer.sv
verif/tb_multi_channel_input_debouncer.sv
